@@ rtl/fdmd_pkg.sv @@
// Shared types, constants and helper functions of the frame difference
// motion detector. Used by fdmd_ctrl, fdmd_datapath and the top level.
package fdmd_pkg;

  localparam int PIX_W   = 8;
  localparam int WGT_W   = 8;
  localparam int THR_W   = 32;
  localparam int SUM_W   = 27;
  localparam int SLOT_W  = 6;
  localparam int CNT_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W  = SUM_W + WGT_W;

  localparam int DEF_WINDOW = 30;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd3;

  localparam logic [WGT_W-1:0] RST_WEIGHT_RED   = 8'd16;
  localparam logic [WGT_W-1:0] RST_WEIGHT_GREEN = 8'd0;
  localparam logic [WGT_W-1:0] RST_WEIGHT_BLUE  = 8'd16;
  localparam logic [THR_W-1:0] RST_THRESHOLD    = 32'd2000000;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accum;    // add the accepted pixel's differences
    logic store;    // write sums to the ring, form products, latch scan flag
    logic decide;   // motion test and window restart
    logic scan_rd;  // read the next ring slot for the scan
    logic finish;   // load the result register and advance frame state
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic scan;       // this frame closes the window
    logic scan_last;  // the last ring slot is being read
    logic out_free;   // result register can take a new result
  } sts_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sums_t;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                input logic [PIX_W-1:0] d);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + {{(SUM_W + 1 - PIX_W){1'b0}}, d};
    sat_add = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

@@ rtl/fdmd_ctrl.sv @@
// Controller of the frame difference motion detector: sequences the
// end-of-frame work (store, decide, ring scan, result). Uses fdmd_pkg.
module fdmd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            frame_end_i,
  output logic            in_stall_o,
  input  fdmd_pkg::sts_t  sts_i,
  output fdmd_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] ST_ACCUM  = 3'd0;
  localparam logic [2:0] ST_STORE  = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_ACCUM);
  assign accept     = in_valid_i && (state_q == ST_ACCUM);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_ACCUM: begin
        cmd_o.accum = accept;
        if (accept && frame_end_i) state_d = ST_STORE;
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = sts_i.scan ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        // last compare happens in this cycle
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = sts_i.out_free;
        if (sts_i.out_free) state_d = ST_ACCUM;
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/fdmd_datapath.sv @@
// Datapath of the frame difference motion detector: accumulators, ring
// memory, motion test, quietest-slot scan and result register. Uses fdmd_pkg.
module fdmd_datapath #(
  parameter int WINDOW = fdmd_pkg::DEF_WINDOW
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fdmd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fdmd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [fdmd_pkg::PIX_W-1:0]        cur_blue_i,
  input  logic [fdmd_pkg::PIX_W-1:0]        cur_green_i,
  input  logic [fdmd_pkg::PIX_W-1:0]        cur_red_i,
  input  logic [fdmd_pkg::PIX_W-1:0]        prev_blue_i,
  input  logic [fdmd_pkg::PIX_W-1:0]        prev_green_i,
  input  logic [fdmd_pkg::PIX_W-1:0]        prev_red_i,
  input  logic                              prev_valid_i,
  input  logic                              out_stall_i,
  input  fdmd_pkg::cmd_t                    cmd_i,
  output fdmd_pkg::sts_t                    sts_o,
  output logic                              out_valid_o,
  output logic [fdmd_pkg::SUM_W-1:0]        sum_red_o,
  output logic [fdmd_pkg::SUM_W-1:0]        sum_green_o,
  output logic [fdmd_pkg::SUM_W-1:0]        sum_blue_o,
  output logic                              motion_o,
  output logic                              best_valid_o,
  output logic [fdmd_pkg::SLOT_W-1:0]       best_slot_o,
  output logic [fdmd_pkg::SLOT_W-1:0]       frame_slot_o
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
  localparam logic [fdmd_pkg::CNT_W-1:0] WIN_CNT = fdmd_pkg::CNT_W'(WINDOW);

  // configuration
  logic [fdmd_pkg::WGT_W-1:0] w_red_q, w_green_q, w_blue_q;
  logic [fdmd_pkg::THR_W-1:0] thr_q;

  // frame state
  fdmd_pkg::sums_t             acc_q;
  logic [IDX_W-1:0]            slot_q;
  logic [fdmd_pkg::CNT_W-1:0]  frame_cnt_q, win_start_q;
  logic                        scan_q;

  // end-of-frame work
  logic [fdmd_pkg::PROD_W-1:0] prod_red_q, prod_green_q, prod_blue_q;
  logic                        motion_q;
  logic [IDX_W-1:0]            best_q;

  // ring and scan
  fdmd_pkg::sums_t             ring_q [WINDOW];
  fdmd_pkg::sums_t             rd_data_q;
  fdmd_pkg::sums_t             min_q;
  logic [IDX_W-1:0]            scan_idx_q, rd_idx_q;
  logic                        rd_valid_q;

  logic [fdmd_pkg::THR_W+3:0]  thr16;
  logic                        motion;
  logic [fdmd_pkg::CNT_W-1:0]  elapsed;

  assign thr16   = {thr_q, 4'b0000};
  assign motion  = ({1'b0, prod_red_q} >= thr16) || ({1'b0, prod_green_q} >= thr16) ||
                   ({1'b0, prod_blue_q} >= thr16);
  assign elapsed = frame_cnt_q - win_start_q;

  assign sts_o.scan      = scan_q;
  assign sts_o.scan_last = (scan_idx_q == LAST_IDX);
  assign sts_o.out_free  = !out_valid_o || !out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_red_q   <= fdmd_pkg::RST_WEIGHT_RED;
      w_green_q <= fdmd_pkg::RST_WEIGHT_GREEN;
      w_blue_q  <= fdmd_pkg::RST_WEIGHT_BLUE;
      thr_q     <= fdmd_pkg::RST_THRESHOLD;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fdmd_pkg::CFG_WEIGHT_RED:   w_red_q   <= cfg_data_i[fdmd_pkg::WGT_W-1:0];
        fdmd_pkg::CFG_WEIGHT_GREEN: w_green_q <= cfg_data_i[fdmd_pkg::WGT_W-1:0];
        fdmd_pkg::CFG_WEIGHT_BLUE:  w_blue_q  <= cfg_data_i[fdmd_pkg::WGT_W-1:0];
        fdmd_pkg::CFG_THRESHOLD:    thr_q     <= cfg_data_i[fdmd_pkg::THR_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // frame control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      slot_q      <= '0;
      frame_cnt_q <= '0;
      win_start_q <= '0;
      scan_q      <= 1'b0;
      rd_valid_q  <= 1'b0;
      scan_idx_q  <= '0;
      out_valid_o <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.scan_rd;
      if (cmd_i.accum && prev_valid_i) begin
        acc_q.blue  <= fdmd_pkg::sat_add(acc_q.blue,
                                         fdmd_pkg::abs_diff(cur_blue_i, prev_blue_i));
        acc_q.green <= fdmd_pkg::sat_add(acc_q.green,
                                         fdmd_pkg::abs_diff(cur_green_i, prev_green_i));
        acc_q.red   <= fdmd_pkg::sat_add(acc_q.red,
                                         fdmd_pkg::abs_diff(cur_red_i, prev_red_i));
      end
      if (cmd_i.store) begin
        scan_q     <= (frame_cnt_q == win_start_q + WIN_CNT);
        scan_idx_q <= '0;
      end
      if (cmd_i.decide && motion && (elapsed >= WIN_CNT)) begin
        win_start_q <= frame_cnt_q;
      end
      if (cmd_i.scan_rd) begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end
      if (cmd_i.finish) begin
        acc_q       <= '0;
        frame_cnt_q <= frame_cnt_q + 1'b1;
        slot_q      <= (slot_q == LAST_IDX) ? '0 : slot_q + 1'b1;
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      ring_q[slot_q] <= acc_q;
    end
    if (cmd_i.scan_rd) begin
      rd_data_q <= ring_q[scan_idx_q];
      rd_idx_q  <= scan_idx_q;
    end
  end

  // products, motion, scan minima and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      prod_red_q   <= fdmd_pkg::PROD_W'(acc_q.red) * fdmd_pkg::PROD_W'(w_red_q);
      prod_green_q <= fdmd_pkg::PROD_W'(acc_q.green) * fdmd_pkg::PROD_W'(w_green_q);
      prod_blue_q  <= fdmd_pkg::PROD_W'(acc_q.blue) * fdmd_pkg::PROD_W'(w_blue_q);
      best_q       <= '0;
    end
    if (cmd_i.decide) begin
      motion_q <= motion;
    end
    if (rd_valid_q) begin
      // slot zero seeds the minima; later slots win on any lower channel
      if (rd_idx_q == '0) begin
        min_q <= rd_data_q;
      end else if ((rd_data_q.red < min_q.red) || (rd_data_q.green < min_q.green) ||
                   (rd_data_q.blue < min_q.blue)) begin
        min_q  <= rd_data_q;
        best_q <= rd_idx_q;
      end
    end
    if (cmd_i.finish) begin
      sum_red_o    <= acc_q.red;
      sum_green_o  <= acc_q.green;
      sum_blue_o   <= acc_q.blue;
      motion_o     <= motion_q;
      best_valid_o <= scan_q;
      best_slot_o  <= fdmd_pkg::SLOT_W'(best_q);
      frame_slot_o <= fdmd_pkg::SLOT_W'(slot_q);
    end
  end

endmodule

@@ rtl/frame_difference_motion_detector_unit.sv @@
// Top level of the frame difference motion detector: controller plus
// datapath. Depends on fdmd_pkg, fdmd_ctrl and fdmd_datapath.
//
// Usage: pixels enter on the input channel (in_valid_i / in_stall_o), each
// with current and previous-frame BGR, prev_valid_i and frame_end_i. A pixel
// without frame_end_i gives no result, so pixels stream at one per cycle
// until a frame end. The frame_end_i pixel gives one result on the output
// channel (out_valid_o / out_stall_i): frame sums, motion flag, the ring
// slot used and, when the window closes, the quietest slot. After a
// frame_end_i pixel the input stalls through store, decide, a ring scan (one
// slot read per cycle from the single ring read port) and drain when the
// window closes, and finish, which loads the result. A pending result does
// not stop pixel intake; only the next frame end waits until the receiver
// has taken it. Reset clears sums, slot, frame and window counters and loads
// the default weights and threshold; ring contents stay undefined until
// written. The user makes configuration writes (cfg_we_i) only while no
// frame end is in flight; the block does not enforce this.
module frame_difference_motion_detector_unit #(
  parameter int WINDOW = fdmd_pkg::DEF_WINDOW
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fdmd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fdmd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [fdmd_pkg::PIX_W-1:0]      cur_blue_i,
  input  logic [fdmd_pkg::PIX_W-1:0]      cur_green_i,
  input  logic [fdmd_pkg::PIX_W-1:0]      cur_red_i,
  input  logic [fdmd_pkg::PIX_W-1:0]      prev_blue_i,
  input  logic [fdmd_pkg::PIX_W-1:0]      prev_green_i,
  input  logic [fdmd_pkg::PIX_W-1:0]      prev_red_i,
  input  logic                            prev_valid_i,
  input  logic                            frame_end_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [fdmd_pkg::SUM_W-1:0]      sum_red_o,
  output logic [fdmd_pkg::SUM_W-1:0]      sum_green_o,
  output logic [fdmd_pkg::SUM_W-1:0]      sum_blue_o,
  output logic                            motion_o,
  output logic                            best_valid_o,
  output logic [fdmd_pkg::SLOT_W-1:0]     best_slot_o,
  output logic [fdmd_pkg::SLOT_W-1:0]     frame_slot_o
);

  fdmd_pkg::cmd_t cmd;
  fdmd_pkg::sts_t sts;

  fdmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .frame_end_i (frame_end_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fdmd_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cur_blue_i   (cur_blue_i),
    .cur_green_i  (cur_green_i),
    .cur_red_i    (cur_red_i),
    .prev_blue_i  (prev_blue_i),
    .prev_green_i (prev_green_i),
    .prev_red_i   (prev_red_i),
    .prev_valid_i (prev_valid_i),
    .out_stall_i  (out_stall_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .sum_red_o    (sum_red_o),
    .sum_green_o  (sum_green_o),
    .sum_blue_o   (sum_blue_o),
    .motion_o     (motion_o),
    .best_valid_o (best_valid_o),
    .best_slot_o  (best_slot_o),
    .frame_slot_o (frame_slot_o)
  );

  // a new result never overwrites one the receiver has not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !(out_valid_o && out_stall_i))
    else $error("result register overwritten while stalled");

  // a result appears only after the controller finished a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.finish))
    else $error("result without finish command");

  // reported slots stay inside the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, frame_slot_o} < 7'(WINDOW)) && ({1'b0, best_slot_o} < 7'(WINDOW)))
    else $error("slot outside the ring");

  // the ring is only read while input intake is held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_rd |-> in_stall_o && !cmd.accum)
    else $error("scan overlaps pixel intake");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench of frame_difference_motion_detector_unit.
// A built-in predictor follows the frame sums, motion flag, ring slot and quietest-slot scan.
// Depends on fdmd_pkg and the RTL of the detector only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIX_W      = fdmd_pkg::PIX_W;
  localparam int WGT_W      = fdmd_pkg::WGT_W;
  localparam int THR_W      = fdmd_pkg::THR_W;
  localparam int SUM_W      = fdmd_pkg::SUM_W;
  localparam int SLOT_W     = fdmd_pkg::SLOT_W;
  localparam int CNT_W      = fdmd_pkg::CNT_W;
  localparam int CFG_IDX_W  = fdmd_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = fdmd_pkg::CFG_DATA_W;

  localparam int RING_LEN = fdmd_pkg::DEF_WINDOW;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned SETTLE_CYCLES = RING_LEN + 10;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0] cur_r;
    logic [PIX_W-1:0] cur_g;
    logic [PIX_W-1:0] cur_b;
    logic [PIX_W-1:0] prev_r;
    logic [PIX_W-1:0] prev_g;
    logic [PIX_W-1:0] prev_b;
    logic             prev_valid;
    logic             frame_end;
  } pixel_t;

  typedef struct packed {
    logic [SUM_W-1:0]  red;
    logic [SUM_W-1:0]  green;
    logic [SUM_W-1:0]  blue;
    logic              motion;
    logic              best_valid;
    logic [SLOT_W-1:0] best_slot;
    logic [SLOT_W-1:0] frame_slot;
  } frame_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  pixel_t                pix_now = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SUM_W-1:0]      sum_red, sum_green, sum_blue;
  logic                  motion, best_valid;
  logic [SLOT_W-1:0]     best_slot, frame_slot;

  frame_difference_motion_detector_unit #(
    .WINDOW(RING_LEN)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .cur_blue_i  (pix_now.cur_b),
    .cur_green_i (pix_now.cur_g),
    .cur_red_i   (pix_now.cur_r),
    .prev_blue_i (pix_now.prev_b),
    .prev_green_i(pix_now.prev_g),
    .prev_red_i  (pix_now.prev_r),
    .prev_valid_i(pix_now.prev_valid),
    .frame_end_i (pix_now.frame_end),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .sum_red_o   (sum_red),
    .sum_green_o (sum_green),
    .sum_blue_o  (sum_blue),
    .motion_o    (motion),
    .best_valid_o(best_valid),
    .best_slot_o (best_slot),
    .frame_slot_o(frame_slot)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [WGT_W-1:0]  wgt_r = fdmd_pkg::RST_WEIGHT_RED;
  logic [WGT_W-1:0]  wgt_g = fdmd_pkg::RST_WEIGHT_GREEN;
  logic [WGT_W-1:0]  wgt_b = fdmd_pkg::RST_WEIGHT_BLUE;
  logic [THR_W-1:0]  motion_thr = fdmd_pkg::RST_THRESHOLD;
  logic [SUM_W-1:0]  acc_r = '0, acc_g = '0, acc_b = '0;
  logic [SUM_W-1:0]  ring_r [RING_LEN];
  logic [SUM_W-1:0]  ring_g [RING_LEN];
  logic [SUM_W-1:0]  ring_b [RING_LEN];
  logic [SLOT_W-1:0] write_slot = '0;
  logic [CNT_W-1:0]  frame_count = '0;
  logic [CNT_W-1:0]  window_start = '0;

  pixel_t        pixel_q[$];
  frame_result_t predicted_frames[$];
  frame_result_t want;

  bit          calm = 1'b0;
  int unsigned send_pause = 0;
  int unsigned stall_left = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned pixels_seen = 0, frames_seen = 0, motion_frames = 0;
  int unsigned scans = 0, saturated_sums = 0;

  function automatic logic [PIX_W-1:0] chan_diff(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [SUM_W-1:0] clip_add(logic [SUM_W-1:0] a, logic [PIX_W-1:0] d);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W + 1)'(d);
    return (s > {1'b0, fdmd_pkg::SUM_MAX}) ? fdmd_pkg::SUM_MAX : s[SUM_W-1:0];
  endfunction

  function automatic logic over_line(logic [SUM_W-1:0] s, logic [WGT_W-1:0] w);
    return 64'(s) * 64'(w) >= 64'(motion_thr) * 64'd16;
  endfunction

  // fold one accepted pixel into the frame sums; a frame end yields one result
  function automatic void absorb_pixel(pixel_t p);
    frame_result_t r;
    logic [SLOT_W-1:0] slot;
    logic [SUM_W-1:0] min_r, min_g, min_b;
    logic [CNT_W-1:0] since_start;
    pixels_seen++;
    if (p.prev_valid) begin
      acc_r = clip_add(acc_r, chan_diff(p.cur_r, p.prev_r));
      acc_g = clip_add(acc_g, chan_diff(p.cur_g, p.prev_g));
      acc_b = clip_add(acc_b, chan_diff(p.cur_b, p.prev_b));
    end
    if (!p.frame_end) return;
    slot = write_slot;
    ring_r[slot] = acc_r;
    ring_g[slot] = acc_g;
    ring_b[slot] = acc_b;
    r.best_valid = (frame_count == window_start + CNT_W'(RING_LEN));
    r.best_slot = '0;
    if (r.best_valid) begin
      // a slot wins when any channel undercuts its running minimum
      min_r = ring_r[0];
      min_g = ring_g[0];
      min_b = ring_b[0];
      for (int i = 0; i < RING_LEN; i++) begin
        if (ring_r[i] < min_r || ring_g[i] < min_g || ring_b[i] < min_b) begin
          min_r = ring_r[i];
          min_g = ring_g[i];
          min_b = ring_b[i];
          r.best_slot = SLOT_W'(i);
        end
      end
      scans++;
    end
    r.motion = over_line(acc_r, wgt_r) || over_line(acc_g, wgt_g) || over_line(acc_b, wgt_b);
    since_start = frame_count - window_start;
    if (r.motion && since_start >= CNT_W'(RING_LEN)) window_start = frame_count;
    r.red = acc_r;
    r.green = acc_g;
    r.blue = acc_b;
    r.frame_slot = slot;
    predicted_frames.push_back(r);
    frames_seen++;
    if (r.motion) motion_frames++;
    if (acc_r == fdmd_pkg::SUM_MAX || acc_g == fdmd_pkg::SUM_MAX ||
        acc_b == fdmd_pkg::SUM_MAX) saturated_sums++;
    frame_count++;
    write_slot = (slot == SLOT_W'(RING_LEN - 1)) ? '0 : slot + 1'b1;
    acc_r = '0;
    acc_g = '0;
    acc_b = '0;
  endfunction

  // mostly short pauses, a few long ones, none in calm stretches
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_pause <= 0;
    end else begin
      if (in_valid && !in_stall) absorb_pixel(pix_now);
      if (!(in_valid && in_stall)) begin
        if (send_pause > 0) begin
          in_valid <= 1'b0;
          send_pause <= send_pause - 1;
        end else if (pixel_q.size() > 0) begin
          pix_now <= pixel_q.pop_front();
          in_valid <= 1'b1;
          send_pause <= pick_pause();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input longint unsigned exp_val,
                             input longint unsigned got_val);
    if (exp_val != got_val) begin
      if (errors < 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, got_val);
      errors++;
    end
  endtask

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_frames.size() == 0) begin
          if (errors < 40)
            $display("%0t: unexpected result, expected none, actual slot %0d", $time,
                     frame_slot);
          errors++;
        end else begin
          want = predicted_frames.pop_front();
          check_field("sum_red", want.red, sum_red);
          check_field("sum_green", want.green, sum_green);
          check_field("sum_blue", want.blue, sum_blue);
          check_field("motion", want.motion, motion);
          check_field("best_valid", want.best_valid, best_valid);
          check_field("best_slot", want.best_slot, best_slot);
          check_field("frame_slot", want.frame_slot, frame_slot);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= pick_pause();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, predicted_frames.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      fdmd_pkg::CFG_WEIGHT_RED:   wgt_r = data[WGT_W-1:0];
      fdmd_pkg::CFG_WEIGHT_GREEN: wgt_g = data[WGT_W-1:0];
      fdmd_pkg::CFG_WEIGHT_BLUE:  wgt_b = data[WGT_W-1:0];
      fdmd_pkg::CFG_THRESHOLD:    motion_thr = data[THR_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_weights(input logic [WGT_W-1:0] r, input logic [WGT_W-1:0] g,
                             input logic [WGT_W-1:0] b, input logic [THR_W-1:0] thr);
    // junk in the upper bits must not reach the 8 bit weights
    write_reg(fdmd_pkg::CFG_WEIGHT_RED, {$urandom} & 32'hFFFF_FF00 | 32'(r));
    write_reg(fdmd_pkg::CFG_WEIGHT_GREEN, {$urandom} & 32'hFFFF_FF00 | 32'(g));
    write_reg(fdmd_pkg::CFG_WEIGHT_BLUE, {$urandom} & 32'hFFFF_FF00 | 32'(b));
    write_reg(fdmd_pkg::CFG_THRESHOLD, thr);
  endtask

  // hold until all pixels are taken and every frame result is back
  task automatic settle();
    while (pixel_q.size() != 0 || in_valid || predicted_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_frame(input int unsigned len, input bit quiet, input bit blind);
    pixel_t p;
    for (int unsigned i = 0; i < len; i++) begin
      p = '0;
      p.cur_r = PIX_W'($urandom);
      p.cur_g = PIX_W'($urandom);
      p.cur_b = PIX_W'($urandom);
      p.prev_r = PIX_W'($urandom);
      p.prev_g = PIX_W'($urandom);
      p.prev_b = PIX_W'($urandom);
      if (quiet) begin
        p.prev_r = p.cur_r ^ PIX_W'($urandom_range(0, 3));
        p.prev_g = p.cur_g ^ PIX_W'($urandom_range(0, 3));
        p.prev_b = p.cur_b ^ PIX_W'($urandom_range(0, 3));
      end
      p.prev_valid = !blind && ($urandom_range(0, 9) != 0);
      p.frame_end = (i == len - 1);
      pixel_q.push_back(p);
    end
  endtask

  task automatic queue_random_frames(input int unsigned n_pixels);
    int unsigned len, left;
    left = n_pixels;
    while (left > 0) begin
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 60);
      if (len > left) len = left;
      queue_frame(len, $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
      left -= len;
    end
  endtask

  initial begin
    pixel_t p;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed frames under the reset configuration
    pixel_q.push_back(pixel_t'{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0});
    pixel_q.push_back(pixel_t'{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0});
    pixel_q.push_back(pixel_t'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0});
    pixel_q.push_back(pixel_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0});
    pixel_q.push_back(pixel_t'{8'd200, 8'd9, 8'd77, 8'd10, 8'd250, 8'd3, 1'b0, 1'b0});
    pixel_q.push_back(pixel_t'{8'd17, 8'd34, 8'd51, 8'd100, 8'd3, 8'd250, 1'b1, 1'b1});
    pixel_q.push_back(pixel_t'{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1});
    pixel_q.push_back(pixel_t'{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 1'b1, 1'b1});
    pixel_q.push_back(pixel_t'{8'd170, 8'd85, 8'd1, 8'd85, 8'd170, 8'd254, 1'b1, 1'b1});
    settle();

    // motion test right at the threshold, then one above it
    p = pixel_t'{8'd255, 8'd0, 8'd9, 8'd0, 8'd255, 8'd9, 1'b1, 1'b1};
    write_reg(fdmd_pkg::CFG_THRESHOLD, 32'd255);
    pixel_q.push_back(p);
    settle();
    write_reg(fdmd_pkg::CFG_THRESHOLD, 32'd256);
    pixel_q.push_back(p);
    settle();

    // full weights with zero threshold; a write to an unused index changes nothing
    set_weights(8'd255, 8'd255, 8'd255, '0);
    write_reg(CFG_NO_REG, $urandom);
    queue_random_frames(200);
    settle();

    // zero weights still meet a zero threshold
    calm = 1'b1;
    set_weights(8'd0, 8'd0, 8'd0, '0);
    queue_random_frames(100);
    settle();
    calm = 1'b0;
    queue_random_frames(50);
    settle();

    // random weights and thresholds near typical frame sums
    for (int ph = 0; ph < 8; ph++) begin
      calm = ($urandom_range(0, 3) == 0);
      set_weights(WGT_W'($urandom), WGT_W'($urandom), WGT_W'($urandom),
                  $urandom_range(0, 9000));
      queue_random_frames(150);
      settle();
    end

    $display("Ran %0d pixels in %0d frames: %0d with motion, %0d ring scans,", pixels_seen,
             frames_seen, motion_frames, scans);
    $display("%0d frames with a saturated sum, %0d cycles.", saturated_sums, cycles);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
